// ===== rtl/atfp_pkg.sv =====
// Shared types, constants and digit decode functions for the target frame parser.
package atfp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned CENTER_W = 10;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned DIGITS   = 6;
    localparam int unsigned DIGIT_IX_W = 3;

    localparam logic [BYTE_W-1:0] HEAD_F     = 8'h46;
    localparam logic [BYTE_W-1:0] HEAD_E     = 8'h45;
    localparam logic [BYTE_W-1:0] TAIL_A     = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

    localparam logic [POS_W-1:0] POS_HEAD_F     = 4'd0;
    localparam logic [POS_W-1:0] POS_HEAD_E     = 4'd1;
    localparam logic [POS_W-1:0] POS_FIRST_DIGIT = 4'd2;
    localparam logic [POS_W-1:0] POS_LAST_DIGIT = 4'd7;
    localparam logic [POS_W-1:0] POS_TAIL       = 4'd8;

    localparam logic [CENTER_W-1:0] CENTER_RESET = 10'd490;
    localparam logic [VALUE_W-1:0]  OFFSET_RESET = 16'd11;

    localparam logic REG_CENTER_X = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0]         echo_byte;
        logic                      frame_done;
        logic                      target_found;
        logic                      found_ever;
        logic signed [VALUE_W-1:0] x_pos;
        logic signed [VALUE_W-1:0] y_pos;
        logic signed [VALUE_W-1:0] x_error;
    } result_t;

    function automatic logic signed [VALUE_W-1:0] digit_value(input logic [BYTE_W-1:0] b);
        digit_value = $signed({{(VALUE_W-BYTE_W){1'b0}}, b})
                    - $signed({{(VALUE_W-BYTE_W){1'b0}}, ASCII_ZERO});
    endfunction

    function automatic logic signed [VALUE_W-1:0] decode3(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] c
    );
        logic signed [VALUE_W-1:0] hundreds;
        logic signed [VALUE_W-1:0] tens;
        hundreds = digit_value(a) * 16'sd100;
        tens     = digit_value(b) * 16'sd10;
        decode3  = hundreds + tens + digit_value(c);
    endfunction

endpackage

// ===== rtl/atfp_cfg.sv =====
// APB register block holding the horizontal centre setting.
module atfp_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [atfp_pkg::CENTER_W-1:0] center_x
);
    import atfp_pkg::*;

    logic [CENTER_W-1:0] center_reg;
    logic [CENTER_W-1:0] center_next;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CENTER_X);

    always_comb
    begin
        center_next = center_reg;
        if (wr_en)
        begin
            center_next = pwdata[CENTER_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= CENTER_RESET;
        end
        else
        begin
            center_reg <= center_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CENTER_X)
        begin
            prdata = {{(32-CENTER_W){1'b0}}, center_reg};
        end
    end

    assign center_x = center_reg;

endmodule

// ===== rtl/atfp_decode.sv =====
// Frame position tracking, digit capture and position decode.
module atfp_decode (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [atfp_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [atfp_pkg::CENTER_W-1:0] center_x,
    output atfp_pkg::result_t             result
);
    import atfp_pkg::*;

    logic [POS_W-1:0]          position_reg;
    logic [POS_W-1:0]          position_next;
    logic [BYTE_W-1:0]         digit_reg [DIGITS];
    logic [DIGIT_IX_W-1:0]     digit_ix;
    logic                      digit_we;
    logic signed [VALUE_W-1:0] x_reg;
    logic signed [VALUE_W-1:0] x_next;
    logic signed [VALUE_W-1:0] y_reg;
    logic signed [VALUE_W-1:0] y_next;
    logic signed [VALUE_W-1:0] offset_reg;
    logic signed [VALUE_W-1:0] offset_next;
    logic                      found_now_reg;
    logic                      found_now_next;
    logic                      found_once_reg;
    logic                      found_once_next;
    logic                      done;
    logic                      all_nine;
    logic signed [VALUE_W-1:0] x_dec;
    logic signed [VALUE_W-1:0] y_dec;

    assign digit_we = (position_reg >= POS_FIRST_DIGIT) && (position_reg <= POS_LAST_DIGIT);
    assign digit_ix = position_reg[DIGIT_IX_W-1:0] - POS_FIRST_DIGIT[DIGIT_IX_W-1:0];

    always_comb
    begin
        all_nine = 1'b1;
        for (int k = 0; k < DIGITS; k++)
        begin
            if (digit_reg[k] != ASCII_NINE)
            begin
                all_nine = 1'b0;
            end
        end
    end

    assign x_dec = decode3(digit_reg[0], digit_reg[1], digit_reg[2]);
    assign y_dec = decode3(digit_reg[3], digit_reg[4], digit_reg[5]);
    assign done  = (position_reg == POS_TAIL) && (rx_byte == TAIL_A);

    always_comb
    begin
        priority if (position_reg == POS_HEAD_F)
        begin
            position_next = (rx_byte == HEAD_F) ? POS_HEAD_E : POS_HEAD_F;
        end
        else if (position_reg == POS_HEAD_E)
        begin
            position_next = (rx_byte == HEAD_E) ? POS_FIRST_DIGIT : POS_HEAD_F;
        end
        else if (position_reg >= POS_TAIL)
        begin
            position_next = POS_HEAD_F;
        end
        else
        begin
            position_next = position_reg + 4'd1;
        end
    end

    always_comb
    begin
        x_next          = x_reg;
        y_next          = y_reg;
        offset_next     = offset_reg;
        found_now_next  = found_now_reg;
        found_once_next = found_once_reg;
        if (done)
        begin
            if (all_nine)
            begin
                found_now_next = 1'b0;
            end
            else
            begin
                x_next          = x_dec;
                y_next          = y_dec;
                offset_next     = x_dec - $signed({{(VALUE_W-CENTER_W){1'b0}}, center_x});
                found_now_next  = 1'b1;
                found_once_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= POS_HEAD_F;
            x_reg          <= '0;
            y_reg          <= '0;
            offset_reg     <= OFFSET_RESET;
            found_now_reg  <= 1'b0;
            found_once_reg <= 1'b0;
        end
        else if (accept)
        begin
            position_reg   <= position_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            offset_reg     <= offset_next;
            found_now_reg  <= found_now_next;
            found_once_reg <= found_once_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && digit_we)
        begin
            digit_reg[digit_ix] <= rx_byte;
        end
    end

    always_comb
    begin
        result.echo_byte    = rx_byte;
        result.frame_done   = done;
        result.target_found = found_now_next;
        result.found_ever   = found_once_next;
        result.x_pos        = x_next;
        result.y_pos        = y_next;
        result.x_error      = offset_next;
    end

    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= POS_TAIL)
        else $error("frame position out of range");

    a_done_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && done) |=> (position_reg == POS_HEAD_F))
        else $error("position not rewound after a completed frame");

    a_found_implies_ever: assert property (@(posedge clk) disable iff (!rst_n)
        found_now_reg |-> found_once_reg)
        else $error("found flag set without found-ever flag");

endmodule

// ===== rtl/atfp_skid.sv =====
// Output result register with a skid stage so input acceptance survives a stalled receiver.
module atfp_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  atfp_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output atfp_pkg::result_t out_data
);
    import atfp_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    in_acc;
    logic    out_free;

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || in_acc;
            skid_valid_next = 1'b0;
        end
        else if (in_acc)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (in_acc)
            begin
                out_data_reg <= in_data;
            end
        end
        else if (in_acc)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a transaction ahead of the output register");

    a_stalled_accept_parks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && in_acc) |=> skid_valid_reg)
        else $error("transaction accepted under stall was not parked");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !skid_valid_reg && !in_acc) |=> !out_valid_reg)
        else $error("output register kept a delivered transaction");

endmodule

// ===== rtl/ascii_target_frame_parser_unit.sv =====
// Top level of the ASCII target frame parser: config port, decode and result buffer.
// Usage:
//   Input channel item_valid / item_stall / rx_byte carries one received byte per
//   transaction. Result channel result_valid / result_stall carries one result per
//   byte: the echoed byte, a frame-done strobe, the found and found-ever flags and the
//   last decoded x, y and x error.
//   Frames are 'F', 'E', six ASCII digits, 'A'; all-nines digits clear the found flag.
//   The APB port holds center_x at byte address 0 (reset 490); write it while idle.
// Result path: each result is registered in the result register, or parked in the skid stage under result_stall.
// Throughput: one byte per cycle while item_stall is low, set by the single decode
//   stage feeding the result register.
// Reset: rst_n clears the frame position, flags and decoded values (x error 11)
//   and empties the result buffer; captured digit bytes are not cleared.
// Stall: with result_stall high one more byte is taken into a skid stage; item_stall
//   then rises until the receiver drains the result register.
module ascii_target_frame_parser_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [atfp_pkg::BYTE_W-1:0]        rx_byte,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [atfp_pkg::BYTE_W-1:0]        echo_byte,
    output logic                               frame_done,
    output logic                               target_found,
    output logic                               found_ever,
    output logic signed [atfp_pkg::VALUE_W-1:0] x_pos,
    output logic signed [atfp_pkg::VALUE_W-1:0] y_pos,
    output logic signed [atfp_pkg::VALUE_W-1:0] x_error
);
    import atfp_pkg::*;

    logic [CENTER_W-1:0] center_x;
    logic                item_acc;
    result_t             dec_result;
    result_t             out_result;

    assign item_acc = item_valid && !item_stall;

    atfp_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .center_x (center_x)
    );

    atfp_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (item_acc),
        .rx_byte  (rx_byte),
        .center_x (center_x),
        .result   (dec_result)
    );

    atfp_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid),
        .in_stall  (item_stall),
        .in_data   (dec_result),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (out_result)
    );

    assign echo_byte    = out_result.echo_byte;
    assign frame_done   = out_result.frame_done;
    assign target_found = out_result.target_found;
    assign found_ever   = out_result.found_ever;
    assign x_pos        = out_result.x_pos;
    assign y_pos        = out_result.y_pos;
    assign x_error      = out_result.x_error;

endmodule
